[rtl/cscan_request_scheduler_top_assert.svh]
// ----------------------------------------------------------------------------
// C-SCAN scheduler assertion macros
// Clocked on clk_i, held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CSCAN_REQUEST_SCHEDULER_TOP_ASSERT_SVH
`define CSCAN_REQUEST_SCHEDULER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define CSCAN_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CSCAN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CSCAN_ASSERT_IMPL(label, ante, cons, msg)
`define CSCAN_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[rtl/cscan_pkg.sv]
// ----------------------------------------------------------------------------
// C-SCAN scheduler package
// Shared widths, result codes and the control bundle for the cell row.
// ----------------------------------------------------------------------------
package cscan_pkg;

  localparam int unsigned QueueDepthDefault = 32;
  localparam int unsigned SectorBitsDefault = 48;
  localparam int unsigned LenW              = 16;
  localparam int unsigned IdW               = 8;

  typedef enum logic [1:0] {
    ST_ADDED      = 2'd0,
    ST_DISPATCHED = 2'd1,
    ST_EMPTY      = 2'd2,
    ST_FULL       = 2'd3
  } status_e;

  typedef enum logic {
    REQ_ADD      = 1'b0,
    REQ_DISPATCH = 1'b1
  } req_type_e;

  // control bundle broadcast to every cell
  typedef struct packed {
    logic do_ins;     // insert the new word at its sorted place
    logic do_pop;     // shift the row toward the head
    logic cur_sweep;  // current sweep set
    logic new_sweep;  // sweep set of the new word
  } chain_ctl_t;

endpackage

[rtl/cscan_cell.sv]
// ----------------------------------------------------------------------------
// C-SCAN scheduler cell
// One slot of the sorted row: keeps a request, decides locally whether the
// new word belongs in front of it, and hands data to its neighbors.
// ----------------------------------------------------------------------------
module cscan_cell
  import cscan_pkg::*;
#(
  parameter int unsigned SECTOR_BITS = SectorBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  chain_ctl_t             ctl_i,
  input  logic [SECTOR_BITS-1:0] new_start_i,
  input  logic [LenW-1:0]        new_len_i,
  input  logic [IdW-1:0]         new_id_i,
  input  logic                   prev_ins_i,
  input  logic                   prev_valid_i,
  input  logic                   prev_sweep_i,
  input  logic [SECTOR_BITS-1:0] prev_start_i,
  input  logic [LenW-1:0]        prev_len_i,
  input  logic [IdW-1:0]         prev_id_i,
  input  logic                   next_valid_i,
  input  logic                   next_sweep_i,
  input  logic [SECTOR_BITS-1:0] next_start_i,
  input  logic [LenW-1:0]        next_len_i,
  input  logic [IdW-1:0]         next_id_i,
  output logic                   ins_o,
  output logic                   valid_o,
  output logic                   sweep_o,
  output logic [SECTOR_BITS-1:0] start_o,
  output logic [LenW-1:0]        len_o,
  output logic [IdW-1:0]         id_o
);

  logic                   valid_q, valid_d;
  logic                   sweep_q, sweep_d;
  logic [SECTOR_BITS-1:0] start_q, start_d;
  logic [LenW-1:0]        len_q, len_d;
  logic [IdW-1:0]         id_q, id_d;
  logic [SECTOR_BITS:0]   own_key, new_key;

  // key: other-set flag above the start sector, so the current set sorts first
  assign own_key = {sweep_q != ctl_i.cur_sweep, start_q};
  assign new_key = {ctl_i.new_sweep != ctl_i.cur_sweep, new_start_i};

  // strictly greater keeps equal keys in arrival order
  assign ins_o = !valid_q || (own_key > new_key);

  always_comb begin
    valid_d = valid_q;
    sweep_d = sweep_q;
    start_d = start_q;
    len_d   = len_q;
    id_d    = id_q;
    if (ctl_i.do_ins && ins_o) begin
      if (prev_ins_i) begin
        valid_d = prev_valid_i;
        sweep_d = prev_sweep_i;
        start_d = prev_start_i;
        len_d   = prev_len_i;
        id_d    = prev_id_i;
      end else begin
        valid_d = 1'b1;
        sweep_d = ctl_i.new_sweep;
        start_d = new_start_i;
        len_d   = new_len_i;
        id_d    = new_id_i;
      end
    end else if (ctl_i.do_pop) begin
      valid_d = next_valid_i;
      sweep_d = next_sweep_i;
      start_d = next_start_i;
      len_d   = next_len_i;
      id_d    = next_id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sweep_q <= sweep_d;
    start_q <= start_d;
    len_q   <= len_d;
    id_q    <= id_d;
  end

  assign valid_o = valid_q;
  assign sweep_o = sweep_q;
  assign start_o = start_q;
  assign len_o   = len_q;
  assign id_o    = id_q;

endmodule

[rtl/cscan_chain.sv]
// ----------------------------------------------------------------------------
// C-SCAN scheduler cell row
// QUEUE_DEPTH cells kept sorted by (set, start, age); the head is next out.
// ----------------------------------------------------------------------------
module cscan_chain
  import cscan_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault,
  parameter int unsigned SECTOR_BITS = SectorBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  chain_ctl_t             ctl_i,
  input  logic [SECTOR_BITS-1:0] new_start_i,
  input  logic [LenW-1:0]        new_len_i,
  input  logic [IdW-1:0]         new_id_i,
  output logic                   head_valid_o,
  output logic                   head_sweep_o,
  output logic [SECTOR_BITS-1:0] head_start_o,
  output logic [LenW-1:0]        head_len_o,
  output logic [IdW-1:0]         head_id_o,
  output logic                   full_o
);

  // padded with an empty neighbor on each end
  logic                   ins_x   [QUEUE_DEPTH+2];
  logic                   valid_x [QUEUE_DEPTH+2];
  logic                   sweep_x [QUEUE_DEPTH+2];
  logic [SECTOR_BITS-1:0] start_x [QUEUE_DEPTH+2];
  logic [LenW-1:0]        len_x   [QUEUE_DEPTH+2];
  logic [IdW-1:0]         id_x    [QUEUE_DEPTH+2];

  assign ins_x[0]   = 1'b0;
  assign valid_x[0] = 1'b0;
  assign sweep_x[0] = 1'b0;
  assign start_x[0] = '0;
  assign len_x[0]   = '0;
  assign id_x[0]    = '0;

  assign ins_x[QUEUE_DEPTH+1]   = 1'b0;
  assign valid_x[QUEUE_DEPTH+1] = 1'b0;
  assign sweep_x[QUEUE_DEPTH+1] = 1'b0;
  assign start_x[QUEUE_DEPTH+1] = '0;
  assign len_x[QUEUE_DEPTH+1]   = '0;
  assign id_x[QUEUE_DEPTH+1]    = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cscan_cell #(
      .SECTOR_BITS(SECTOR_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl_i),
      .new_start_i (new_start_i),
      .new_len_i   (new_len_i),
      .new_id_i    (new_id_i),
      .prev_ins_i  (ins_x[i]),
      .prev_valid_i(valid_x[i]),
      .prev_sweep_i(sweep_x[i]),
      .prev_start_i(start_x[i]),
      .prev_len_i  (len_x[i]),
      .prev_id_i   (id_x[i]),
      .next_valid_i(valid_x[i+2]),
      .next_sweep_i(sweep_x[i+2]),
      .next_start_i(start_x[i+2]),
      .next_len_i  (len_x[i+2]),
      .next_id_i   (id_x[i+2]),
      .ins_o       (ins_x[i+1]),
      .valid_o     (valid_x[i+1]),
      .sweep_o     (sweep_x[i+1]),
      .start_o     (start_x[i+1]),
      .len_o       (len_x[i+1]),
      .id_o        (id_x[i+1])
    );
  end

  assign head_valid_o = valid_x[1];
  assign head_sweep_o = sweep_x[1];
  assign head_start_o = start_x[1];
  assign head_len_o   = len_x[1];
  assign head_id_o    = id_x[1];
  // occupied cells are packed from the head, so the tail tells full
  assign full_o       = valid_x[QUEUE_DEPTH];

endmodule

[rtl/cscan_request_scheduler_top.sv]
// ----------------------------------------------------------------------------
// C-SCAN request scheduler
// Two sweep sets of pending block requests, dispatched lowest start first.
// ----------------------------------------------------------------------------
// Each word is first registered in the input stage, which picks its sweep
// set against the last dispatched end; from there the row of
// QUEUE_DEPTH cells inserts it at its sorted place or shifts the head out.
// The input stalls while a word is held in that register; a result waits in
// its own output register, so one word may sit there while the next is
// taken in. There is no clearing pass after reset.
`include "cscan_request_scheduler_top_assert.svh"

module cscan_request_scheduler_top
  import cscan_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault,
  parameter int unsigned SECTOR_BITS = SectorBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   req_type_i,
  input  logic [SECTOR_BITS-1:0] start_sector_i,
  input  logic [LenW-1:0]        sector_count_i,
  input  logic [IdW-1:0]         request_id_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             status_o,
  output logic [IdW-1:0]         out_id_o,
  output logic [SECTOR_BITS-1:0] out_start_o,
  output logic [LenW-1:0]        out_count_o,
  output logic                   out_sweep_o
);

  logic                   op_valid_q, op_valid_d;
  req_type_e              op_type_q;
  logic                   op_sweep_q;
  logic [SECTOR_BITS-1:0] op_start_q;
  logic [LenW-1:0]        op_len_q;
  logic [IdW-1:0]         op_id_q;

  logic                   cur_sweep_q, cur_sweep_d;
  logic [SECTOR_BITS:0]   last_end_q, last_end_d;

  logic                   out_valid_q, out_valid_d;
  status_e                out_status_q, out_status_d;
  logic [IdW-1:0]         out_id_q, out_id_d;
  logic [SECTOR_BITS-1:0] out_start_q, out_start_d;
  logic [LenW-1:0]        out_count_q, out_count_d;
  logic                   out_sweep_q, out_sweep_d;

  logic                   in_accept, exec;
  chain_ctl_t             ctl;
  logic                   head_valid, head_sweep, full;
  logic [SECTOR_BITS-1:0] head_start;
  logic [LenW-1:0]        head_len;
  logic [IdW-1:0]         head_id;

  assign in_stall_o = op_valid_q;
  assign in_accept  = in_valid_i && !op_valid_q;
  assign exec       = op_valid_q && (!out_valid_q || !out_stall_i);

  // input stage: hold the word and tag its sweep set
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_type_q  <= req_type_e'(req_type_i);
      op_start_q <= start_sector_i;
      op_len_q   <= sector_count_i;
      op_id_q    <= request_id_i;
      op_sweep_q <= ({1'b0, start_sector_i} > last_end_q) ? cur_sweep_q : !cur_sweep_q;
    end
  end

  always_comb begin
    op_valid_d = op_valid_q;
    if (exec) begin
      op_valid_d = 1'b0;
    end else if (in_accept) begin
      op_valid_d = 1'b1;
    end
  end

  cscan_chain #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .SECTOR_BITS(SECTOR_BITS)
  ) u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .new_start_i (op_start_q),
    .new_len_i   (op_len_q),
    .new_id_i    (op_id_q),
    .head_valid_o(head_valid),
    .head_sweep_o(head_sweep),
    .head_start_o(head_start),
    .head_len_o  (head_len),
    .head_id_o   (head_id),
    .full_o      (full)
  );

  always_comb begin
    ctl.do_ins    = 1'b0;
    ctl.do_pop    = 1'b0;
    ctl.cur_sweep = cur_sweep_q;
    ctl.new_sweep = op_sweep_q;
    cur_sweep_d   = cur_sweep_q;
    last_end_d    = last_end_q;
    out_status_d  = out_status_q;
    out_id_d      = out_id_q;
    out_start_d   = out_start_q;
    out_count_d   = out_count_q;
    out_sweep_d   = out_sweep_q;
    out_valid_d   = out_valid_q && out_stall_i;
    if (exec) begin
      out_valid_d = 1'b1;
      out_id_d    = '0;
      out_start_d = '0;
      out_count_d = '0;
      case (op_type_q)
        REQ_ADD: begin
          out_sweep_d = op_sweep_q;
          if (full) begin
            out_status_d = ST_FULL;
          end else begin
            out_status_d = ST_ADDED;
            ctl.do_ins   = 1'b1;
          end
        end
        REQ_DISPATCH: begin
          if (head_valid) begin
            // an empty current set leaves the other set at the head: flip to it
            ctl.do_pop   = 1'b1;
            cur_sweep_d  = head_sweep;
            last_end_d   = {1'b0, head_start} +
                           {{(SECTOR_BITS + 1 - LenW){1'b0}}, head_len};
            out_status_d = ST_DISPATCHED;
            out_id_d     = head_id;
            out_start_d  = head_start;
            out_count_d  = head_len;
            out_sweep_d  = head_sweep;
          end else begin
            cur_sweep_d  = !cur_sweep_q;
            out_status_d = ST_EMPTY;
            out_sweep_d  = !cur_sweep_q;
          end
        end
        default: begin
          out_status_d = ST_EMPTY;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cur_sweep_q <= 1'b0;
      last_end_q  <= '0;
    end else begin
      op_valid_q  <= op_valid_d;
      out_valid_q <= out_valid_d;
      cur_sweep_q <= cur_sweep_d;
      last_end_q  <= last_end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_id_q     <= out_id_d;
    out_start_q  <= out_start_d;
    out_count_q  <= out_count_d;
    out_sweep_q  <= out_sweep_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign out_id_o    = out_id_q;
  assign out_start_o = out_start_q;
  assign out_count_o = out_count_q;
  assign out_sweep_o = out_sweep_q;

  `CSCAN_ASSERT_IMPL(a_full_packed, full, head_valid, "full row with empty head cell")
  `CSCAN_ASSERT_NEXT(a_ins_lands, ctl.do_ins, head_valid, "insert left the row empty")
  `CSCAN_ASSERT_IMPL(a_sweep_tracks,
    out_valid_q && (out_status_q == ST_DISPATCHED || out_status_q == ST_EMPTY),
    out_sweep_q == cur_sweep_q, "dispatch result set differs from current set")

endmodule

[bench/cscan_request_scheduler_top_tb.sv]
// ----------------------------------------------------------------------------
// C-SCAN request scheduler testbench
// Drives adds and dispatches through the valid/stall input channel, predicts
// every status word from a cycle-free copy of the two sweep sets, and checks
// each output word in order. The receiver stalls on its own pattern and once
// holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module cscan_request_scheduler_top_tb;
  import cscan_pkg::*;

  localparam int unsigned Depth    = QueueDepthDefault;
  localparam int unsigned SectW    = SectorBitsDefault;
  localparam int unsigned IdleMax  = 5000;
  localparam int unsigned HoldOff  = 300;
  localparam int unsigned NumRand  = 630;

  typedef struct {
    logic [1:0]       status;
    logic [IdW-1:0]   id;
    logic [SectW-1:0] start;
    logic [LenW-1:0]  count;
    logic             sweep;
  } sched_word_t;

  // Sweep-set predictor plus the queue of status words still owed.
  class sweep_order_board;
    bit               used_q   [Depth];
    bit               set_q    [Depth];
    logic [SectW-1:0] start_q  [Depth];
    logic [LenW-1:0]  len_q    [Depth];
    logic [IdW-1:0]   ident_q  [Depth];
    int unsigned      age_q    [Depth];
    bit               cur_set;
    logic [SectW:0]   last_end;
    sched_word_t      owed_q[$];
    int unsigned      errors;

    function new();
      for (int i = 0; i < Depth; i++) begin
        used_q[i] = 0;
        age_q[i]  = 0;
      end
      cur_set  = 0;
      last_end = '0;
      errors   = 0;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    function void note_request(req_type_e rtype, logic [SectW-1:0] s,
                               logic [LenW-1:0] c, logic [IdW-1:0] id);
      sched_word_t w;
      int unsigned n_used;
      int          free_idx;
      int          pick;
      bit          tgt;
      bit          any_cur;
      n_used   = 0;
      free_idx = -1;
      pick     = -1;
      any_cur  = 0;
      w.status = ST_ADDED;
      w.id     = '0;
      w.start  = '0;
      w.count  = '0;
      for (int i = 0; i < Depth; i++) begin
        if (used_q[i]) n_used++;
        else if (free_idx < 0) free_idx = i;
      end
      if (rtype == REQ_ADD) begin
        tgt     = ({1'b0, s} > last_end) ? cur_set : ~cur_set;
        w.sweep = tgt;
        if (free_idx < 0) begin
          w.status = ST_FULL;
        end else begin
          used_q[free_idx]  = 1;
          set_q[free_idx]   = tgt;
          start_q[free_idx] = s;
          len_q[free_idx]   = c;
          ident_q[free_idx] = id;
          age_q[free_idx]   = n_used;
        end
      end else begin
        for (int i = 0; i < Depth; i++)
          if (used_q[i] && set_q[i] == cur_set) any_cur = 1;
        // flip when the current set is empty, even if both are
        if (!any_cur) cur_set = ~cur_set;
        for (int i = 0; i < Depth; i++) begin
          if (!used_q[i] || set_q[i] != cur_set) continue;
          if (pick < 0 || start_q[i] < start_q[pick] ||
              (start_q[i] == start_q[pick] && age_q[i] < age_q[pick]))
            pick = i;
        end
        w.sweep = cur_set;
        if (pick < 0) begin
          w.status = ST_EMPTY;
        end else begin
          w.status = ST_DISPATCHED;
          w.id     = ident_q[pick];
          w.start  = start_q[pick];
          w.count  = len_q[pick];
          last_end = {1'b0, start_q[pick]} + {{(SectW+1-LenW){1'b0}}, len_q[pick]};
          used_q[pick] = 0;
          for (int i = 0; i < Depth; i++)
            if (used_q[i] && age_q[i] > age_q[pick]) age_q[i]--;
        end
      end
      owed_q.push_back(w);
    endfunction

    function void check_reply(logic [1:0] st, logic [IdW-1:0] id,
                              logic [SectW-1:0] s, logic [LenW-1:0] c,
                              logic sw);
      sched_word_t w;
      if (owed_q.size() == 0) begin
        $error("unexpected output word: status %0d id %0d", st, id);
        errors++;
        return;
      end
      w = owed_q.pop_front();
      if (st !== w.status) begin
        $error("status: expected %0d, actual %0d", w.status, st);
        errors++;
      end
      if (id !== w.id) begin
        $error("out_id: expected %0d, actual %0d", w.id, id);
        errors++;
      end
      if (s !== w.start) begin
        $error("out_start: expected %0h, actual %0h", w.start, s);
        errors++;
      end
      if (c !== w.count) begin
        $error("out_count: expected %0h, actual %0h", w.count, c);
        errors++;
      end
      if (sw !== w.sweep) begin
        $error("out_sweep: expected %0d, actual %0d", w.sweep, sw);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i          = 1'b0;
  logic             rst_ni         = 1'b0;
  logic             in_valid_i     = 1'b0;
  logic             in_stall_o;
  logic             req_type_i     = 1'b0;
  logic [SectW-1:0] start_sector_i = '0;
  logic [LenW-1:0]  sector_count_i = '0;
  logic [IdW-1:0]   request_id_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i    = 1'b0;
  logic [1:0]       status_o;
  logic [IdW-1:0]   out_id_o;
  logic [SectW-1:0] out_start_o;
  logic [LenW-1:0]  out_count_o;
  logic             out_sweep_o;

  sweep_order_board board;
  bit               hold_req = 0;
  int unsigned      idle_cycles = 0;

  cscan_request_scheduler_top #(
    .QUEUE_DEPTH(Depth),
    .SECTOR_BITS(SectW)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .start_sector_i (start_sector_i),
    .sector_count_i (sector_count_i),
    .request_id_i   (request_id_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .out_id_o       (out_id_o),
    .out_start_o    (out_start_o),
    .out_count_o    (out_count_o),
    .out_sweep_o    (out_sweep_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Sample both channels on the edge; values seen here are pre-edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        board.note_request(req_type_e'(req_type_i), start_sector_i,
                           sector_count_i, request_id_i);
      if (out_valid_o && !out_stall_i)
        board.check_reply(status_o, out_id_o, out_start_o, out_count_o,
                          out_sweep_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= IdleMax) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver stall pattern: segments of free flow, light, heavy and periodic
  // stalling, plus one long hold-off on request.
  initial begin : stall_gen
    int unsigned seg_left;
    int unsigned mode;
    int unsigned cyc;
    bit          held;
    seg_left = 0;
    mode     = 0;
    cyc      = 0;
    held     = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (hold_req && !held) begin
        held = 1;
        out_stall_i <= 1'b1;
        repeat (HoldOff) @(posedge clk_i);
        out_stall_i <= 1'b0;
        seg_left = 0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(80, 20);
          mode     = $urandom_range(3, 0);
        end
        seg_left--;
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(99, 0) < 30);
          2: out_stall_i <= ($urandom_range(99, 0) < 70);
          default: out_stall_i <= ((cyc % 4) == 0);
        endcase
      end
    end
  end

  // Offer one word after an optional gap; return at the accepting edge.
  task automatic send_req(req_type_e rtype, logic [SectW-1:0] s,
                          logic [LenW-1:0] c, logic [IdW-1:0] id,
                          int unsigned gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= rtype;
    start_sector_i <= s;
    sector_count_i <= c;
    request_id_i   <= id;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // step past the accepting edge so the last word is already noted
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [SectW-1:0] pick_start();
    logic [SectW-1:0] le;
    le = board.last_end[SectW-1:0];
    case ($urandom_range(4, 0))
      0: return SectW'($urandom_range(63, 0));
      1: return SectW'({$urandom, $urandom});
      2: return le + SectW'($urandom_range(4, 0)) - SectW'(2);
      3: return $urandom_range(1, 0) ? '1 : '0;
      default: return SectW'({$urandom, $urandom}) & SectW'(48'h0000_0000_FFFF);
    endcase
  endfunction

  function automatic logic [LenW-1:0] pick_count();
    case ($urandom_range(3, 0))
      0: return LenW'($urandom_range(15, 0));
      1: return $urandom_range(1, 0) ? '1 : '0;
      default: return LenW'($urandom);
    endcase
  endfunction

  initial begin : stim
    int unsigned burst_left;
    int unsigned seg_left;
    int unsigned seg_mode;
    int unsigned gap;
    int unsigned add_pct;
    req_type_e   rtype;
    board      = new();
    burst_left = 0;
    seg_left   = 0;
    seg_mode   = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty dispatch, start extremes, ties, end-sector boundaries
    send_req(REQ_DISPATCH, '0, '0, '0, 0);
    send_req(REQ_ADD, '0, '0, '0, 0);
    send_req(REQ_ADD, 48'd1, 16'd3, 8'd1, 0);
    send_req(REQ_ADD, '1, '1, '1, 1);
    send_req(REQ_ADD, 48'd5, 16'd2, 8'd10, 0);
    send_req(REQ_ADD, 48'd5, 16'd7, 8'd11, 0);
    send_req(REQ_ADD, 48'd5, 16'd1, 8'd12, 2);
    send_req(REQ_DISPATCH, '1, '1, '1, 0);
    send_req(REQ_DISPATCH, '0, '0, '0, 0);
    send_req(REQ_DISPATCH, '0, '0, '0, 0);
    send_req(REQ_ADD, 48'd9, 16'd4, 8'd20, 0);
    send_req(REQ_ADD, board.last_end[SectW-1:0], 16'd1, 8'd21, 0);
    send_req(REQ_ADD, board.last_end[SectW-1:0] + 1'b1, 16'd1, 8'd22, 0);
    send_req(REQ_DISPATCH, '0, '0, '0, 0);
    send_req(REQ_DISPATCH, '0, '0, '0, 3);
    send_req(REQ_DISPATCH, '0, '0, '0, 0);
    send_req(REQ_DISPATCH, '0, '0, '0, 0);
    // last end is now sector 0, after the top request and the flip to the other set
    send_req(REQ_ADD, '1, 16'd0, 8'h80, 0);
    send_req(REQ_DISPATCH, '0, '0, '0, 0);
    send_req(REQ_DISPATCH, '0, '0, '0, 0);
    send_req(REQ_DISPATCH, '0, '0, '0, 0);
    wait_drained();

    for (int i = 0; i < NumRand; i++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(60, 15);
        seg_mode = $urandom_range(2, 0);
      end
      seg_left--;
      add_pct = (seg_mode == 0) ? 85 : (seg_mode == 1) ? 25 : 50;
      rtype = ($urandom_range(99, 0) < add_pct) ? REQ_ADD : REQ_DISPATCH;

      if (i == 200) hold_req = 1;
      if (i == 420) wait_drained();

      if (i >= 200 && i < 240) begin
        gap = 0;  // keep offering through the hold-off
      end else if (burst_left == 0) begin
        burst_left = ($urandom_range(9, 0) == 0) ? 60 : $urandom_range(16, 1);
        gap        = $urandom_range(6, 1);
      end else begin
        gap = 0;
      end
      if (burst_left > 0) burst_left--;

      send_req(rtype, pick_start(), pick_count(), IdW'($urandom), gap);
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (board.pending() != 0) begin
      $error("%0d output words never arrived", board.pending());
      board.errors++;
    end
    if (board.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/cscan_pkg.sv
rtl/cscan_cell.sv
rtl/cscan_chain.sv
rtl/cscan_request_scheduler_top.sv
bench/cscan_request_scheduler_top_tb.sv
